### rtl/clrm_pkg.sv
// Package for the chunk list range mapper.
// Holds the field widths, the queue sizing, the item structs and the command/result codes.
// No dependencies.
`timescale 1ns / 1ps

package clrm_pkg;

  // Field widths
  localparam int OFFSET_BITS = 48;
  localparam int BLOCK_BITS  = 24;
  localparam int COUNT_BITS  = 16;
  localparam int CLEN_BITS   = BLOCK_BITS + 1;

  // Result queue sizing
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Input command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_CHUNK = 1'b1;

  // Result kind codes
  localparam logic KIND_RANGE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  // Status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_NEG = 1'b1;

  typedef struct packed {
    logic                          cmd;
    logic signed [OFFSET_BITS-1:0] req_offset;
    logic [OFFSET_BITS-1:0]        req_length;
    logic [COUNT_BITS-1:0]         num_chunks;
    logic [BLOCK_BITS-1:0]         chunk_block;
    logic [BLOCK_BITS-1:0]         chunk_start;
    logic [CLEN_BITS-1:0]          chunk_length;
  } in_item_t;

  typedef struct packed {
    logic                   result_kind;
    logic [BLOCK_BITS-1:0]  range_block;
    logic [BLOCK_BITS-1:0]  range_start;
    logic [CLEN_BITS-1:0]   range_length;
    logic [OFFSET_BITS-1:0] total_bytes;
    logic                   status;
    logic                   last;
  } out_item_t;

endpackage

### rtl/chunk_list_range_mapper.sv
// Datapath: an input transaction is captured in the input register, computed from it and
// written into a four-entry result queue, from which its first result is taken; the input
// register holds while the queue lacks room for two results.
// Throughput: one input transaction per cycle while the queue has room, set by the single
// compute stage; the queue drains one result per cycle while out_stall is low.
// Reset: synchronous on rst_n low; clears request state, the input stage and the queue.
//
// Top level: maps a byte read request onto a streamed list of chunk descriptors.
// Depends on clrm_pkg.
`timescale 1ns / 1ps

module chunk_list_range_mapper (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  clrm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output clrm_pkg::out_item_t out_data
);

  // Input stage
  logic               s1_valid_r, s1_valid_nxt;
  clrm_pkg::in_item_t s1_data_r;

  // Request state
  logic [clrm_pkg::OFFSET_BITS-1:0] skip_r,   skip_nxt;
  logic [clrm_pkg::OFFSET_BITS-1:0] mapped_r, mapped_nxt;
  logic [clrm_pkg::OFFSET_BITS-1:0] room_r,   room_nxt;
  logic [clrm_pkg::COUNT_BITS-1:0]  left_r,   left_nxt;
  logic                             started_r, started_nxt;
  logic                             halted_r,  halted_nxt;

  // Result queue
  clrm_pkg::out_item_t              fifo_r [clrm_pkg::FIFO_DEPTH];
  logic [clrm_pkg::PTR_W-1:0]       head_r, head_nxt;
  logic [clrm_pkg::PTR_W-1:0]       tail_r, tail_nxt;
  logic [clrm_pkg::CNT_W-1:0]       count_r, count_nxt;

  logic                             pop;
  logic [clrm_pkg::CNT_W-1:0]       count_eff;
  logic                             room_ok;
  logic                             advance;
  logic                             load;

  // Compute signals
  logic                             neg;
  logic [clrm_pkg::COUNT_BITS-1:0]  left_dec;
  logic                             want;
  logic                             mapped_zero;
  logic                             skip_ge;
  logic                             do_skip;
  logic [clrm_pkg::CLEN_BITS-1:0]   diff;
  logic [clrm_pkg::CLEN_BITS-1:0]   len;
  logic [1:0]                       push_n;
  clrm_pkg::out_item_t              res0, res1, range_res, done_res;

  // Handshake and queue space
  assign pop       = (count_r != '0) && !out_stall;
  assign count_eff = count_r - clrm_pkg::CNT_W'(pop);
  assign room_ok   = count_eff <= clrm_pkg::CNT_W'(clrm_pkg::FIFO_DEPTH - 2);
  assign advance   = s1_valid_r && room_ok;
  assign in_stall  = s1_valid_r && !room_ok;
  assign load      = in_valid && !in_stall;
  assign s1_valid_nxt = load || (s1_valid_r && !advance);

  assign out_valid = (count_r != '0);
  assign out_data  = fifo_r[head_r];

  // Chunk arithmetic
  assign neg         = s1_data_r.req_offset[clrm_pkg::OFFSET_BITS-1];
  assign left_dec    = left_r - 1'b1;
  assign want        = (room_r != '0);
  assign mapped_zero = (mapped_r == '0);
  assign skip_ge     = skip_r >= clrm_pkg::OFFSET_BITS'(s1_data_r.chunk_length);
  assign do_skip     = mapped_zero && skip_ge;
  assign diff        = s1_data_r.chunk_length - skip_r[clrm_pkg::CLEN_BITS-1:0];
  assign len         = (room_r < clrm_pkg::OFFSET_BITS'(diff))
                     ? room_r[clrm_pkg::CLEN_BITS-1:0] : diff;

  // Build results and next state
  always_comb begin
    skip_nxt    = skip_r;
    mapped_nxt  = mapped_r;
    room_nxt    = room_r;
    left_nxt    = left_r;
    started_nxt = started_r;
    halted_nxt  = halted_r;
    push_n      = 2'd0;

    range_res              = '0;
    range_res.result_kind  = clrm_pkg::KIND_RANGE;
    range_res.range_block  = s1_data_r.chunk_block;
    range_res.range_start  = s1_data_r.chunk_start
                           + skip_r[clrm_pkg::BLOCK_BITS-1:0];
    range_res.range_length = len;
    range_res.status       = clrm_pkg::STATUS_OK;
    range_res.last         = (left_dec != '0);

    done_res             = '0;
    done_res.result_kind = clrm_pkg::KIND_DONE;
    done_res.status      = clrm_pkg::STATUS_OK;
    done_res.last        = 1'b1;

    res0 = done_res;
    res1 = done_res;

    if (advance) begin
      if (s1_data_r.cmd == clrm_pkg::CMD_START) begin
        // Open a new request, dropping any open one
        skip_nxt   = neg ? '0 : $unsigned(s1_data_r.req_offset);
        room_nxt   = s1_data_r.req_length;
        mapped_nxt = '0;
        left_nxt   = s1_data_r.num_chunks;
        if (neg) begin
          started_nxt = 1'b0;
          halted_nxt  = (s1_data_r.num_chunks != '0);
          res0.status = clrm_pkg::STATUS_NEG;
          push_n      = 2'd1;
        end else begin
          halted_nxt  = 1'b0;
          started_nxt = (s1_data_r.num_chunks != '0);
          if (s1_data_r.num_chunks == '0) begin
            push_n = 2'd1;
          end
        end
      end else if (halted_r) begin
        // Swallow chunks of a rejected request
        left_nxt = left_dec;
        if (left_dec == '0) begin
          halted_nxt = 1'b0;
        end
      end else if (started_r && (left_r != '0)) begin
        left_nxt = left_dec;
        if (want && do_skip) begin
          skip_nxt = skip_r - clrm_pkg::OFFSET_BITS'(s1_data_r.chunk_length);
        end else if (want) begin
          mapped_nxt = mapped_r + clrm_pkg::OFFSET_BITS'(len);
          room_nxt   = room_r - clrm_pkg::OFFSET_BITS'(len);
          skip_nxt   = '0;
          res0       = range_res;
          push_n     = 2'd1;
        end
        // Close the request on its final chunk
        if (left_dec == '0) begin
          started_nxt = 1'b0;
          if (want && !do_skip) begin
            res1.total_bytes = mapped_r + clrm_pkg::OFFSET_BITS'(len);
            push_n           = 2'd2;
          end else begin
            res0.total_bytes = mapped_r;
            push_n           = 2'd1;
          end
        end
      end
    end
  end

  // Queue pointers
  always_comb begin
    head_nxt  = head_r + clrm_pkg::PTR_W'(pop);
    tail_nxt  = tail_r + clrm_pkg::PTR_W'(push_n);
    count_nxt = count_eff + clrm_pkg::CNT_W'(push_n);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      skip_r     <= '0;
      mapped_r   <= '0;
      room_r     <= '0;
      left_r     <= '0;
      started_r  <= 1'b0;
      halted_r   <= 1'b0;
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      skip_r     <= skip_nxt;
      mapped_r   <= mapped_nxt;
      room_r     <= room_nxt;
      left_r     <= left_nxt;
      started_r  <= started_nxt;
      halted_r   <= halted_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
    end
  end

  // Payload registers: input stage and queue entries
  always_ff @(posedge clk) begin
    if (load) begin
      s1_data_r <= in_data;
    end
    if (push_n != 2'd0) begin
      fifo_r[tail_r] <= res0;
    end
    if (push_n == 2'd2) begin
      fifo_r[tail_r + 1'b1] <= res1;
    end
  end

  // Queue never overfills
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= clrm_pkg::CNT_W'(clrm_pkg::FIFO_DEPTH))
    else $error("result queue count exceeds depth");

  // A request is never both open and rejected
  assert property (@(posedge clk) disable iff (!rst_n)
    !(started_r && halted_r))
    else $error("started and halted both set");

  // An open request always expects more chunks
  assert property (@(posedge clk) disable iff (!rst_n)
    (started_r || halted_r) |-> (left_r != '0))
    else $error("open request with no chunks left");

  // Queue pointers stay consistent with the count
  assert property (@(posedge clk) disable iff (!rst_n)
    (head_r + clrm_pkg::PTR_W'(count_r) == tail_r)
    || (count_r == clrm_pkg::CNT_W'(clrm_pkg::FIFO_DEPTH)))
    else $error("queue pointers disagree with count");

endmodule
